// ===== rtl/core/sts_pkg.sv =====
// Shared types, token kind codes and character classification for the script token scanner.
// No dependencies; every other file of the scanner imports this package.
package sts_pkg;

	localparam int TOKEN_KIND_W   = 6;
	localparam int TOKEN_LINE_W   = 16;
	localparam int TOKEN_START_W  = 24;
	localparam int TOKEN_LENGTH_W = 8;

	localparam logic [5:0] KIND_END          = 6'd0;
	localparam logic [5:0] KIND_IDENT        = 6'd1;
	localparam logic [5:0] KIND_STRUCT       = 6'd2;
	localparam logic [5:0] KIND_FN           = 6'd3;
	localparam logic [5:0] KIND_SELF         = 6'd4;
	localparam logic [5:0] KIND_IF           = 6'd5;
	localparam logic [5:0] KIND_ELSIF        = 6'd6;
	localparam logic [5:0] KIND_ELSE         = 6'd7;
	localparam logic [5:0] KIND_RETURN       = 6'd8;
	localparam logic [5:0] KIND_INC          = 6'd9;
	localparam logic [5:0] KIND_ADD_ASSIGN   = 6'd10;
	localparam logic [5:0] KIND_PLUS         = 6'd11;
	localparam logic [5:0] KIND_DEC          = 6'd12;
	localparam logic [5:0] KIND_SUB_ASSIGN   = 6'd13;
	localparam logic [5:0] KIND_ARROW        = 6'd14;
	localparam logic [5:0] KIND_MINUS        = 6'd15;
	localparam logic [5:0] KIND_EQ           = 6'd16;
	localparam logic [5:0] KIND_ASSIGN       = 6'd17;
	localparam logic [5:0] KIND_NE           = 6'd18;
	localparam logic [5:0] KIND_NOT          = 6'd19;
	localparam logic [5:0] KIND_GE           = 6'd20;
	localparam logic [5:0] KIND_GT           = 6'd21;
	localparam logic [5:0] KIND_LE           = 6'd22;
	localparam logic [5:0] KIND_LT           = 6'd23;
	localparam logic [5:0] KIND_STAR         = 6'd24;
	localparam logic [5:0] KIND_SLASH        = 6'd25;
	localparam logic [5:0] KIND_COLON        = 6'd26;
	localparam logic [5:0] KIND_HASH         = 6'd27;
	localparam logic [5:0] KIND_DOT          = 6'd28;
	localparam logic [5:0] KIND_COMMA        = 6'd29;
	localparam logic [5:0] KIND_SEMI         = 6'd30;
	localparam logic [5:0] KIND_LPAREN       = 6'd31;
	localparam logic [5:0] KIND_RPAREN       = 6'd32;
	localparam logic [5:0] KIND_LBRACKET     = 6'd33;
	localparam logic [5:0] KIND_RBRACKET     = 6'd34;
	localparam logic [5:0] KIND_LBRACE       = 6'd35;
	localparam logic [5:0] KIND_RBRACE       = 6'd36;
	localparam logic [5:0] KIND_UNKNOWN      = 6'd37;

	// Keyword text packed with the first character in the low byte.
	localparam logic [63:0] KW_TEXT_STRUCT = 64'h0000_7463_7572_7473;
	localparam logic [63:0] KW_TEXT_FN     = 64'h0000_0000_0000_6e66;
	localparam logic [63:0] KW_TEXT_SELF   = 64'h0000_0000_666c_6573;
	localparam logic [63:0] KW_TEXT_IF     = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_TEXT_ELSIF  = 64'h0000_0066_6973_6c65;
	localparam logic [63:0] KW_TEXT_ELSE   = 64'h0000_0000_6573_6c65;
	localparam logic [63:0] KW_TEXT_RETURN = 64'h0000_6e72_7574_6572;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} sts_src_t;

	typedef struct packed {
		logic [TOKEN_KIND_W-1:0]   token_kind;
		logic [TOKEN_LINE_W-1:0]   token_line;
		logic [TOKEN_START_W-1:0]  token_start;
		logic [TOKEN_LENGTH_W-1:0] token_length;
		logic                      run_last;
	} sts_tok_t;

	typedef struct packed {
		logic [1:0]          count;
		sts_tok_t [2:0]      words;
	} sts_push_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_alpha(c) || (c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_held_start(input logic [7:0] c);
		logic r;
		case (c) inside
			"+", "-", "=", "!", ">", "<": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"=": k = KIND_ASSIGN;
			"!": k = KIND_NOT;
			">": k = KIND_GT;
			"<": k = KIND_LT;
			"*": k = KIND_STAR;
			"/": k = KIND_SLASH;
			":": k = KIND_COLON;
			"#": k = KIND_HASH;
			".": k = KIND_DOT;
			",": k = KIND_COMMA;
			";": k = KIND_SEMI;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"[": k = KIND_LBRACKET;
			"]": k = KIND_RBRACKET;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// Returns KIND_END when the two characters form no operator.
	function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] k;
		k = KIND_END;
		case (a)
			"+": begin
				if (b == "+") k = KIND_INC;
				else if (b == "=") k = KIND_ADD_ASSIGN;
			end
			"-": begin
				if (b == "-") k = KIND_DEC;
				else if (b == "=") k = KIND_SUB_ASSIGN;
				else if (b == ">") k = KIND_ARROW;
			end
			"=": if (b == "=") k = KIND_EQ;
			"!": if (b == "=") k = KIND_NE;
			">": if (b == "=") k = KIND_GE;
			"<": if (b == "=") k = KIND_LE;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] keyword_kind(input logic [63:0] text, input logic [7:0] len);
		logic [5:0] k;
		k = KIND_IDENT;
		if (len == 8'd6 && text == KW_TEXT_STRUCT) k = KIND_STRUCT;
		else if (len == 8'd2 && text == KW_TEXT_FN) k = KIND_FN;
		else if (len == 8'd4 && text == KW_TEXT_SELF) k = KIND_SELF;
		else if (len == 8'd2 && text == KW_TEXT_IF) k = KIND_IF;
		else if (len == 8'd5 && text == KW_TEXT_ELSIF) k = KIND_ELSIF;
		else if (len == 8'd4 && text == KW_TEXT_ELSE) k = KIND_ELSE;
		else if (len == 8'd6 && text == KW_TEXT_RETURN) k = KIND_RETURN;
		return k;
	endfunction

endpackage

// ===== rtl/core/sts_token_queue.sv =====
// Result queue of the script token scanner: takes up to three token words a cycle, gives one unless stalled.
// Depends on sts_pkg for the token word and push group types.
module sts_token_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  sts_pkg::sts_push_t push,
	output logic              room,
	output logic              tok_valid,
	input  logic              tok_stall,
	output sts_pkg::sts_tok_t  tok_word
);
	import sts_pkg::*;

	localparam int DEPTH = 4;

	sts_tok_t   mem [DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop       = tok_valid && !tok_stall;
	assign tok_valid = count_q != 3'd0;
	assign tok_word  = mem[rd_q];
	assign room      = count_q <= 3'(DEPTH - 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.count;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push.count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < push.count) begin
				mem[wr_q + 2'(k)] <= push.words[k];
			end
		end
	end

endmodule

// ===== rtl/core/script_token_scanner.sv =====
// Top level of the script token scanner: input register, scan logic and state, result queue.
// Depends on sts_pkg and sts_token_queue.
//
//   channel  ports                          carries
//   src      src_valid, src_stall, src_word one source byte and its last flag
//   tok      tok_valid, tok_stall, tok_word one token: kind, line, start, length, run_last
//
// A byte is registered on acceptance and scanned from that input register; its tokens are written
// into the result queue when it has room, and tok is driven from the head of that queue.
// One byte per cycle is taken while bytes yield at most one token each and tok is not stalled;
// more tokens from a byte outpace the single-word tok port, and src then stalls on the queue.
// src_stall rises while a byte is held and the four-word result queue cannot take three more words.
// Reset clears the scan state to line one, offset zero, nothing pending.
module script_token_scanner #(
	parameter int OFFSET_WIDTH  = 24,
	parameter int KEYWORD_BYTES = 6,
	parameter int LINE_WIDTH    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  sts_pkg::sts_src_t  src_word,
	output logic              tok_valid,
	input  logic              tok_stall,
	output sts_pkg::sts_tok_t  tok_word
);
	import sts_pkg::*;

	localparam logic [LINE_WIDTH-1:0] LINE_TOP = '1;
	localparam logic [7:0]            KW_LEN   = 8'(KEYWORD_BYTES);

	logic                                src_valid_s1;
	sts_src_t                            src_s1;
	logic                                room;
	logic                                advance;
	sts_push_t                           push;

	logic                                held_q;
	logic [7:0]                          held_op_q;
	logic                                in_word_q;
	logic [7:0]                          word_len_q;
	logic [KEYWORD_BYTES-1:0][7:0]       prefix_q;
	logic [LINE_WIDTH-1:0]               line_q;
	logic [OFFSET_WIDTH-1:0]             offset_q;
	logic [OFFSET_WIDTH-1:0]             begin_q;

	logic                                held_n;
	logic [7:0]                          held_op_n;
	logic                                in_word_n;
	logic [7:0]                          word_len_n;
	logic [KEYWORD_BYTES-1:0][7:0]       prefix_n;
	logic [LINE_WIDTH-1:0]               line_n;
	logic [OFFSET_WIDTH-1:0]             offset_n;
	logic [OFFSET_WIDTH-1:0]             begin_n;

	sts_tok_t [4:0]                      cand;
	logic [4:0]                          cand_v;
	sts_tok_t [2:0]                      slots;
	logic [2:0]                          n_tok;

	function automatic logic [5:0] word_kind(input logic [KEYWORD_BYTES-1:0][7:0] text,
			input logic [7:0] len);
		logic [5:0] k;
		if (len > KW_LEN) k = KIND_IDENT;
		else k = keyword_kind(64'(text), len);
		return k;
	endfunction

	function automatic logic [TOKEN_LINE_W-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
		logic [TOKEN_LINE_W-1:0] r;
		if ((v >> TOKEN_LINE_W) != '0) r = '1;
		else r = TOKEN_LINE_W'(v);
		return r;
	endfunction

	function automatic sts_tok_t make_tok(input logic [5:0] kind,
			input logic [LINE_WIDTH-1:0] line, input logic [OFFSET_WIDTH-1:0] start,
			input logic [7:0] len);
		sts_tok_t t;
		t.token_kind   = kind;
		t.token_line   = sat_line(line);
		t.token_start  = TOKEN_START_W'(start);
		t.token_length = len;
		t.run_last     = 1'b0;
		return t;
	endfunction

	assign advance   = src_valid_s1 && room;
	assign src_stall = src_valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			src_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			src_s1 <= src_word;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic       last;
		logic       nz;
		logic [5:0] pk;
		logic       pair_hit;
		logic       word_cont;
		logic       used;
		logic       other;

		b         = src_s1.source_byte;
		last      = src_s1.end_of_source;
		nz        = b != 8'd0;
		pk        = (held_q && nz) ? pair_kind(held_op_q, b) : KIND_END;
		pair_hit  = pk != KIND_END;
		word_cont = in_word_q && nz && is_word_char(b);
		used      = pair_hit || word_cont;
		other     = 1'b0;

		held_n     = held_q;
		held_op_n  = held_op_q;
		in_word_n  = in_word_q;
		word_len_n = word_len_q;
		prefix_n   = prefix_q;
		line_n     = line_q;
		offset_n   = offset_q;
		begin_n    = begin_q;
		cand       = '0;
		cand_v     = '0;

		cand[0]   = make_tok(pk, line_q, begin_q, 8'd2);
		cand_v[0] = pair_hit;
		if (pair_hit) held_n = 1'b0;

		cand[1]   = make_tok(held_q ? single_kind(held_op_q) : word_kind(prefix_q, word_len_q),
			line_q, begin_q, held_q ? 8'd1 : word_len_q);
		cand_v[1] = !used && (held_q || in_word_q);

		if (word_cont) begin
			for (int i = 0; i < KEYWORD_BYTES; i++) begin
				if (word_len_q == 8'(i)) prefix_n[i] = b;
			end
			if (word_len_q != 8'hFF) word_len_n = word_len_q + 8'd1;
		end

		if (!used) begin
			held_n    = 1'b0;
			in_word_n = 1'b0;
		end

		if (nz && !used) begin
			if (b == 8'h0A) begin
				if (line_q != LINE_TOP) line_n = line_q + LINE_WIDTH'(1);
			end else if (is_space(b)) begin
				other = 1'b0;
			end else if (is_alpha(b)) begin
				in_word_n   = 1'b1;
				begin_n     = offset_q;
				word_len_n  = 8'd1;
				prefix_n    = '0;
				prefix_n[0] = b;
			end else if (is_held_start(b)) begin
				held_n    = 1'b1;
				held_op_n = b;
				begin_n   = offset_q;
			end else begin
				other = 1'b1;
			end
		end

		cand[2]   = make_tok(single_kind(b), line_q, offset_q, 8'd1);
		cand_v[2] = other;

		cand[3]   = make_tok(held_n ? single_kind(held_op_n) : word_kind(prefix_n, word_len_n),
			line_n, begin_n, held_n ? 8'd1 : word_len_n);
		cand_v[3] = nz && last && (held_n || in_word_n);

		cand[4]   = make_tok(KIND_END, line_n, nz ? offset_q + OFFSET_WIDTH'(1) : offset_q, 8'd0);
		cand_v[4] = !nz || last;

		if (!nz || last) begin
			held_n    = 1'b0;
			in_word_n = 1'b0;
			line_n    = LINE_WIDTH'(1);
			offset_n  = '0;
		end else begin
			offset_n = offset_q + OFFSET_WIDTH'(1);
		end
	end

	always_comb begin
		slots = '0;
		n_tok = '0;
		for (int i = 0; i < 5; i++) begin
			if (cand_v[i] && n_tok < 3'd3) begin
				slots[n_tok[1:0]] = cand[i];
				n_tok = n_tok + 3'd1;
			end
		end
		for (int j = 0; j < 3; j++) begin
			slots[j].run_last = (3'(j) + 3'd1) == n_tok;
		end
		push.words = slots;
		push.count = advance ? n_tok[1:0] : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 1'b0;
			held_op_q  <= '0;
			in_word_q  <= 1'b0;
			word_len_q <= '0;
			prefix_q   <= '0;
			line_q     <= LINE_WIDTH'(1);
			offset_q   <= '0;
			begin_q    <= '0;
		end else if (advance) begin
			held_q     <= held_n;
			held_op_q  <= held_op_n;
			in_word_q  <= in_word_n;
			word_len_q <= word_len_n;
			prefix_q   <= prefix_n;
			line_q     <= line_n;
			offset_q   <= offset_n;
			begin_q    <= begin_n;
		end
	end

	sts_token_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_word  (tok_word)
	);

endmodule

// ===== rtl/core/sts_checker.sv =====
// Port-level checks for the script token scanner, attached to the top level by a bind.
// Depends on sts_pkg for the word types and kind codes.
module sts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input sts_pkg::sts_src_t  src_word,
	input logic              tok_valid,
	input logic              tok_stall,
	input sts_pkg::sts_tok_t  tok_word
);
	import sts_pkg::*;

	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_word))
		else $error("source word changed while stalled");

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
		else $error("token word changed while stalled");

	a_end_length: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_word.token_kind == KIND_END) == (tok_word.token_length == '0)))
		else $error("token length does not match end kind");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_word.token_kind == KIND_END |-> tok_word.run_last)
		else $error("end token is not the last token of its byte");

	a_tok_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_word.token_line != '0 && tok_word.token_kind <= KIND_UNKNOWN)
		else $error("token line or kind out of range");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_word  (src_word),
	.tok_valid (tok_valid),
	.tok_stall (tok_stall),
	.tok_word  (tok_word)
);
